// ----- src/ttf_pkg.sv -----
// ----------------------------------------------------------------------------
// ttf_pkg: shared types and constants of the triangle tangent frame block
// Widths of the fixed-point datapath, operand codes and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ttf_pkg;

  // Input coordinates (the fraction position does not change the unit vectors)
  localparam int COORD_W = 32;
  // Coordinate and texture differences
  localparam int DIFF_W = COORD_W + 1;
  // Signed product of two differences
  localparam int PROD_W = 2 * DIFF_W;
  // Accumulator for a difference of two products
  localparam int ACC_W = PROD_W + 2;
  // Scaled vector component: magnitude below 2^(SC_W-1)
  localparam int SC_W = 31;
  localparam int SC_TOP = SC_W - 1;
  // Output format
  localparam int OUT_W = 16;
  localparam int OUT_FRAC_BITS = 14;
  // Integer square root
  localparam int SQ_W = 64;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int LEN_W = SQ_W / 2;
  // Rounded division
  localparam int QW = OUT_FRAC_BITS + 2;
  localparam int QX_W = (QW > OUT_W) ? QW : OUT_W;
  localparam int NUM_W = SC_W + OUT_FRAC_BITS;
  localparam int REM_W = LEN_W + 1;
  localparam int CNT_W = 6;
  localparam int RES_N = 9;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t tex_u;
    coord_t tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tangent_x;
    logic signed [OUT_W-1:0] tangent_y;
    logic signed [OUT_W-1:0] tangent_z;
    logic signed [OUT_W-1:0] bitangent_x;
    logic signed [OUT_W-1:0] bitangent_y;
    logic signed [OUT_W-1:0] bitangent_z;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } frame_t;

  // Multiplier operand sources
  typedef enum logic [4:0] {
    SRC_DU1, SRC_DU2, SRC_DV1, SRC_DV2,
    SRC_E1X, SRC_E1Y, SRC_E1Z,
    SRC_E2X, SRC_E2Y, SRC_E2Z,
    SRC_TX, SRC_TY, SRC_TZ,
    SRC_BX, SRC_BY, SRC_BZ,
    SRC_NX, SRC_NY, SRC_NZ
  } src_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_SUB, ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    VEC_T, VEC_B, VEC_N
  } vec_t;

  typedef struct packed {
    logic         store_corner;
    logic         corner_sel;
    logic         load_diff;
    src_t         a_src;
    src_t         b_src;
    acc_op_t      acc_op;
    logic         latch_det;
    logic         latch_tri;
    logic [1:0]   tri_idx;
    vec_t         vec;
    logic         scale_load;
    logic         scale_step;
    logic         scale_store;
    logic         sq_start;
    logic         sq_step;
    logic         div_start;
    logic         div_step;
    src_t         div_src;
    logic         res_write;
    logic [3:0]   res_idx;
    logic         set_bad;
    logic         put;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic scale_done;
    logic scale_zero;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- src/ttf_if.sv -----
// ----------------------------------------------------------------------------
// ttf_if: request channels of the triangle tangent frame block
// Vertex channel and result channel, each valid/ready with its payload.
// ----------------------------------------------------------------------------
interface ttf_vtx_if;
  logic            valid;
  logic            ready;
  ttf_pkg::coord_t pos_x;
  ttf_pkg::coord_t pos_y;
  ttf_pkg::coord_t pos_z;
  ttf_pkg::coord_t tex_u;
  ttf_pkg::coord_t tex_v;

  modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttf_frame_if;
  logic                             valid;
  logic                             ready;
  logic signed [ttf_pkg::OUT_W-1:0] tangent_x;
  logic signed [ttf_pkg::OUT_W-1:0] tangent_y;
  logic signed [ttf_pkg::OUT_W-1:0] tangent_z;
  logic signed [ttf_pkg::OUT_W-1:0] bitangent_x;
  logic signed [ttf_pkg::OUT_W-1:0] bitangent_y;
  logic signed [ttf_pkg::OUT_W-1:0] bitangent_z;
  logic signed [ttf_pkg::OUT_W-1:0] normal_x;
  logic signed [ttf_pkg::OUT_W-1:0] normal_y;
  logic signed [ttf_pkg::OUT_W-1:0] normal_z;
  logic                             degenerate;

  modport source(output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                 bitangent_y, bitangent_z, normal_x, normal_y, normal_z,
                 degenerate, input ready);
  modport sink(input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
               bitangent_y, bitangent_z, normal_x, normal_y, normal_z,
               degenerate, output ready);
endinterface

// ----- src/ttf_dp.sv -----
// ----------------------------------------------------------------------------
// ttf_dp: datapath of the triangle tangent frame block
// Corner store, differences, one registered multiplier with accumulator,
// power-of-two scaler, bit-serial square root, restoring divider, result reg.
// ----------------------------------------------------------------------------
module ttf_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ttf_pkg::dp_cmd_t  cmd,
  output ttf_pkg::dp_stat_t stat,
  input  ttf_pkg::vtx_t     vtx,
  output ttf_pkg::frame_t   res,
  output logic              res_valid,
  input  logic              res_ready
);

  // corner store
  ttf_pkg::coord_t pos_r [2][3];
  ttf_pkg::coord_t tex_r [2][2];

  // differences
  logic signed [ttf_pkg::DIFF_W-1:0] e1_r [3];
  logic signed [ttf_pkg::DIFF_W-1:0] e2_r [3];
  logic signed [ttf_pkg::DIFF_W-1:0] du1_r, dv1_r, du2_r, dv2_r;

  // scaled vectors
  logic signed [ttf_pkg::SC_W-1:0] ts_r [3];
  logic signed [ttf_pkg::SC_W-1:0] bs_r [3];
  logic signed [ttf_pkg::SC_W-1:0] ns_r [3];

  // multiplier and accumulator
  logic signed [ttf_pkg::PROD_W-1:0] prod_r;
  ttf_pkg::acc_op_t                  op_r;
  logic signed [ttf_pkg::ACC_W-1:0]  acc_r;
  logic                              det_neg_r;
  logic signed [ttf_pkg::ACC_W-1:0]  tri_r [3];

  // scaler
  logic [ttf_pkg::ACC_W-1:0] sm_r [3];
  logic                      sg_r [3];
  logic [ttf_pkg::ACC_W-1:0] orm;

  // square root
  logic [ttf_pkg::SQ_W-1:0] sq_n_r, sq_q_r, sq_b_r;
  logic [ttf_pkg::SQ_W-1:0] sq_rb;
  logic [ttf_pkg::LEN_W-1:0] len;

  // divider
  logic [ttf_pkg::REM_W-1:0] rem_r;
  logic [ttf_pkg::QW-1:0]    nlo_r, q_r;
  logic                      dsign_r;
  logic [ttf_pkg::REM_W-1:0] dt;
  logic [ttf_pkg::NUM_W-1:0] num;
  logic signed [ttf_pkg::DIFF_W-1:0] opa, opb, opd;
  logic [ttf_pkg::DIFF_W-1:0] dmag_w;
  logic [ttf_pkg::QX_W-1:0]  qx;

  // results
  logic [ttf_pkg::OUT_W-1:0] res_r [ttf_pkg::RES_N];
  logic                      bad_r;
  ttf_pkg::frame_t           out_r;
  logic                      out_valid_r;

  function automatic logic signed [ttf_pkg::DIFF_W-1:0] operand(
    input ttf_pkg::src_t s,
    input logic signed [ttf_pkg::DIFF_W-1:0] du1, du2, dv1, dv2,
    input logic signed [ttf_pkg::DIFF_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z,
    input logic signed [ttf_pkg::SC_W-1:0] tx, ty, tz, bx, by, bz, nx, ny, nz
  );
    logic signed [ttf_pkg::DIFF_W-1:0] v;
    case (s)
      ttf_pkg::SRC_DU1: v = du1;
      ttf_pkg::SRC_DU2: v = du2;
      ttf_pkg::SRC_DV1: v = dv1;
      ttf_pkg::SRC_DV2: v = dv2;
      ttf_pkg::SRC_E1X: v = e1x;
      ttf_pkg::SRC_E1Y: v = e1y;
      ttf_pkg::SRC_E1Z: v = e1z;
      ttf_pkg::SRC_E2X: v = e2x;
      ttf_pkg::SRC_E2Y: v = e2y;
      ttf_pkg::SRC_E2Z: v = e2z;
      ttf_pkg::SRC_TX:  v = ttf_pkg::DIFF_W'(tx);
      ttf_pkg::SRC_TY:  v = ttf_pkg::DIFF_W'(ty);
      ttf_pkg::SRC_TZ:  v = ttf_pkg::DIFF_W'(tz);
      ttf_pkg::SRC_BX:  v = ttf_pkg::DIFF_W'(bx);
      ttf_pkg::SRC_BY:  v = ttf_pkg::DIFF_W'(by);
      ttf_pkg::SRC_BZ:  v = ttf_pkg::DIFF_W'(bz);
      ttf_pkg::SRC_NX:  v = ttf_pkg::DIFF_W'(nx);
      ttf_pkg::SRC_NY:  v = ttf_pkg::DIFF_W'(ny);
      ttf_pkg::SRC_NZ:  v = ttf_pkg::DIFF_W'(nz);
      default:          v = '0;
    endcase
    return v;
  endfunction

  // operand selection
  always_comb begin
    opa = operand(cmd.a_src, du1_r, du2_r, dv1_r, dv2_r, e1_r[0], e1_r[1], e1_r[2],
                  e2_r[0], e2_r[1], e2_r[2], ts_r[0], ts_r[1], ts_r[2],
                  bs_r[0], bs_r[1], bs_r[2], ns_r[0], ns_r[1], ns_r[2]);
    opb = operand(cmd.b_src, du1_r, du2_r, dv1_r, dv2_r, e1_r[0], e1_r[1], e1_r[2],
                  e2_r[0], e2_r[1], e2_r[2], ts_r[0], ts_r[1], ts_r[2],
                  bs_r[0], bs_r[1], bs_r[2], ns_r[0], ns_r[1], ns_r[2]);
    opd = operand(cmd.div_src, du1_r, du2_r, dv1_r, dv2_r, e1_r[0], e1_r[1], e1_r[2],
                  e2_r[0], e2_r[1], e2_r[2], ts_r[0], ts_r[1], ts_r[2],
                  bs_r[0], bs_r[1], bs_r[2], ns_r[0], ns_r[1], ns_r[2]);
    dmag_w = opd[ttf_pkg::DIFF_W-1] ? ttf_pkg::DIFF_W'(-opd) : ttf_pkg::DIFF_W'(opd);
  end

  // corners and differences
  always_ff @(posedge clk) begin
    if (cmd.store_corner) begin
      pos_r[cmd.corner_sel][0] <= vtx.pos_x;
      pos_r[cmd.corner_sel][1] <= vtx.pos_y;
      pos_r[cmd.corner_sel][2] <= vtx.pos_z;
      tex_r[cmd.corner_sel][0] <= vtx.tex_u;
      tex_r[cmd.corner_sel][1] <= vtx.tex_v;
    end
    if (cmd.load_diff) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= ttf_pkg::DIFF_W'(pos_r[1][i]) - ttf_pkg::DIFF_W'(pos_r[0][i]);
      end
      e2_r[0] <= ttf_pkg::DIFF_W'(vtx.pos_x) - ttf_pkg::DIFF_W'(pos_r[0][0]);
      e2_r[1] <= ttf_pkg::DIFF_W'(vtx.pos_y) - ttf_pkg::DIFF_W'(pos_r[0][1]);
      e2_r[2] <= ttf_pkg::DIFF_W'(vtx.pos_z) - ttf_pkg::DIFF_W'(pos_r[0][2]);
      du1_r <= ttf_pkg::DIFF_W'(tex_r[1][0]) - ttf_pkg::DIFF_W'(tex_r[0][0]);
      dv1_r <= ttf_pkg::DIFF_W'(tex_r[1][1]) - ttf_pkg::DIFF_W'(tex_r[0][1]);
      du2_r <= ttf_pkg::DIFF_W'(vtx.tex_u) - ttf_pkg::DIFF_W'(tex_r[0][0]);
      dv2_r <= ttf_pkg::DIFF_W'(vtx.tex_v) - ttf_pkg::DIFF_W'(tex_r[0][1]);
    end
  end

  // multiply into a register, then accumulate the product in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    op_r   <= cmd.acc_op;
    case (op_r)
      ttf_pkg::ACC_LOAD: acc_r <= ttf_pkg::ACC_W'(prod_r);
      ttf_pkg::ACC_SUB:  acc_r <= acc_r - ttf_pkg::ACC_W'(prod_r);
      ttf_pkg::ACC_ADD:  acc_r <= acc_r + ttf_pkg::ACC_W'(prod_r);
      default:           acc_r <= acc_r;
    endcase
    if (cmd.latch_det) det_neg_r <= acc_r[ttf_pkg::ACC_W-1];
    // T and B follow the sign of the determinant, N does not
    if (cmd.latch_tri && cmd.tri_idx != 2'd3) begin
      tri_r[cmd.tri_idx] <= (det_neg_r && cmd.vec != ttf_pkg::VEC_N) ? -acc_r : acc_r;
    end
  end

  // power-of-two scaler: magnitudes shifted until the largest is in [2^29, 2^30)
  assign orm = sm_r[0] | sm_r[1] | sm_r[2];

  always_ff @(posedge clk) begin
    if (cmd.scale_load) begin
      for (int i = 0; i < 3; i++) begin
        sg_r[i] <= tri_r[i][ttf_pkg::ACC_W-1];
        sm_r[i] <= tri_r[i][ttf_pkg::ACC_W-1] ? ttf_pkg::ACC_W'(-tri_r[i])
                                               : ttf_pkg::ACC_W'(tri_r[i]);
      end
    end else if (cmd.scale_step) begin
      for (int i = 0; i < 3; i++) begin
        if ((orm >> (ttf_pkg::SC_TOP + 8)) != '0) begin
          sm_r[i] <= sm_r[i] >> 8;
        end else if ((orm >> ttf_pkg::SC_TOP) != '0) begin
          sm_r[i] <= sm_r[i] >> 1;
        end else if ((orm >> (ttf_pkg::SC_TOP - 9)) == '0) begin
          sm_r[i] <= sm_r[i] << 8;
        end else begin
          sm_r[i] <= sm_r[i] << 1;
        end
      end
    end
    if (cmd.scale_store) begin
      for (int i = 0; i < 3; i++) begin
        case (cmd.vec)
          ttf_pkg::VEC_T: ts_r[i] <= sg_r[i] ? -$signed({1'b0, sm_r[i][ttf_pkg::SC_W-2:0]})
                                             : $signed({1'b0, sm_r[i][ttf_pkg::SC_W-2:0]});
          ttf_pkg::VEC_B: bs_r[i] <= sg_r[i] ? -$signed({1'b0, sm_r[i][ttf_pkg::SC_W-2:0]})
                                             : $signed({1'b0, sm_r[i][ttf_pkg::SC_W-2:0]});
          default:        ns_r[i] <= sg_r[i] ? -$signed({1'b0, sm_r[i][ttf_pkg::SC_W-2:0]})
                                             : $signed({1'b0, sm_r[i][ttf_pkg::SC_W-2:0]});
        endcase
      end
    end
  end

  // bit-serial integer square root, two radicand bits per step
  assign sq_rb = sq_q_r + sq_b_r;
  assign len   = sq_q_r[ttf_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      sq_n_r <= acc_r[ttf_pkg::SQ_W-1:0];
      sq_q_r <= '0;
      sq_b_r <= ttf_pkg::SQ_W'(1) << (ttf_pkg::SQ_W - 2);
    end else if (cmd.sq_step) begin
      if (sq_n_r >= sq_rb) begin
        sq_n_r <= sq_n_r - sq_rb;
        sq_q_r <= (sq_q_r >> 1) + sq_b_r;
      end else begin
        sq_q_r <= sq_q_r >> 1;
      end
      sq_b_r <= sq_b_r >> 2;
    end
  end

  // restoring divider: (|c| << frac + len/2) / len, one quotient bit per step
  assign num = (ttf_pkg::NUM_W'(dmag_w[ttf_pkg::SC_W-2:0]) << ttf_pkg::OUT_FRAC_BITS)
             + ttf_pkg::NUM_W'(len >> 1);
  assign dt  = {rem_r[ttf_pkg::REM_W-2:0], nlo_r[ttf_pkg::QW-1]};
  assign qx  = ttf_pkg::QX_W'(q_r);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r   <= ttf_pkg::REM_W'(num >> ttf_pkg::QW);
      nlo_r   <= num[ttf_pkg::QW-1:0];
      q_r     <= '0;
      dsign_r <= opd[ttf_pkg::DIFF_W-1];
    end else if (cmd.div_step) begin
      if (dt >= {1'b0, len}) begin
        rem_r <= dt - {1'b0, len};
        q_r   <= {q_r[ttf_pkg::QW-2:0], 1'b1};
      end else begin
        rem_r <= dt;
        q_r   <= {q_r[ttf_pkg::QW-2:0], 1'b0};
      end
      nlo_r <= nlo_r << 1;
    end
    if (cmd.res_write && cmd.res_idx < 4'(ttf_pkg::RES_N)) begin
      res_r[cmd.res_idx] <= dsign_r ? ttf_pkg::OUT_W'(-qx) : ttf_pkg::OUT_W'(qx);
    end
  end

  // degenerate flag and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_diff) bad_r <= 1'b0;
      else if (cmd.set_bad) bad_r <= 1'b1;
      if (cmd.put) out_valid_r <= 1'b1;
      else if (res_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_r.tangent_x   <= bad_r ? '0 : res_r[0];
      out_r.tangent_y   <= bad_r ? '0 : res_r[1];
      out_r.tangent_z   <= bad_r ? '0 : res_r[2];
      out_r.bitangent_x <= bad_r ? '0 : res_r[3];
      out_r.bitangent_y <= bad_r ? '0 : res_r[4];
      out_r.bitangent_z <= bad_r ? '0 : res_r[5];
      out_r.normal_x    <= bad_r ? '0 : res_r[6];
      out_r.normal_y    <= bad_r ? '0 : res_r[7];
      out_r.normal_z    <= bad_r ? '0 : res_r[8];
      out_r.degenerate  <= bad_r;
    end
  end

  assign res       = out_r;
  assign res_valid = out_valid_r;

  // status
  assign stat.acc_zero   = (acc_r == '0);
  assign stat.scale_zero = (orm == '0);
  assign stat.scale_done = ((orm >> ttf_pkg::SC_TOP) == '0) && orm[ttf_pkg::SC_TOP-1];
  assign stat.out_busy   = out_valid_r && !res_ready;

  a_put_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |=> out_valid_r)
    else $error("result not presented after put");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.degenerate) |->
      (out_r.tangent_x == '0 && out_r.bitangent_y == '0 && out_r.normal_z == '0))
    else $error("degenerate result carries nonzero vectors");

endmodule

// ----- src/ttf_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttf_ctrl: sequencer of the triangle tangent frame block
// Counts corners and steps the datapath through products, scaling, square
// roots and divisions for each triangle.
// ----------------------------------------------------------------------------
module ttf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output ttf_pkg::dp_cmd_t  cmd,
  input  ttf_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAIR, S_SCALE, S_SQ, S_SQRT, S_DIV, S_PUT
  } state_t;

  typedef struct packed {
    ttf_pkg::src_t a0;
    ttf_pkg::src_t b0;
    ttf_pkg::src_t a1;
    ttf_pkg::src_t b1;
    logic [1:0]    idx;
    ttf_pkg::vec_t vec;
  } pair_ops_t;

  state_t                    state_r, state_nxt;
  logic [1:0]                phase_r, phase_nxt;
  logic [3:0]                pair_r, pair_nxt;
  logic [2:0]                sub_r, sub_nxt;
  ttf_pkg::vec_t             vec_r, vec_nxt;
  logic [1:0]                comp_r, comp_nxt;
  logic [ttf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  pair_ops_t                 ops;
  ttf_pkg::src_t             csrc;
  logic [3:0]                rbase;

  // product pairs: determinant, then T, B and N components
  function automatic pair_ops_t pair_ops(input logic [3:0] p);
    pair_ops_t o;
    o = '{ttf_pkg::SRC_DU1, ttf_pkg::SRC_DV2, ttf_pkg::SRC_DU2, ttf_pkg::SRC_DV1,
          2'd0, ttf_pkg::VEC_T};
    case (p)
      4'd1: o = '{ttf_pkg::SRC_DV2, ttf_pkg::SRC_E1X, ttf_pkg::SRC_DV1, ttf_pkg::SRC_E2X,
                  2'd0, ttf_pkg::VEC_T};
      4'd2: o = '{ttf_pkg::SRC_DV2, ttf_pkg::SRC_E1Y, ttf_pkg::SRC_DV1, ttf_pkg::SRC_E2Y,
                  2'd1, ttf_pkg::VEC_T};
      4'd3: o = '{ttf_pkg::SRC_DV2, ttf_pkg::SRC_E1Z, ttf_pkg::SRC_DV1, ttf_pkg::SRC_E2Z,
                  2'd2, ttf_pkg::VEC_T};
      4'd4: o = '{ttf_pkg::SRC_DU1, ttf_pkg::SRC_E2X, ttf_pkg::SRC_DU2, ttf_pkg::SRC_E1X,
                  2'd0, ttf_pkg::VEC_B};
      4'd5: o = '{ttf_pkg::SRC_DU1, ttf_pkg::SRC_E2Y, ttf_pkg::SRC_DU2, ttf_pkg::SRC_E1Y,
                  2'd1, ttf_pkg::VEC_B};
      4'd6: o = '{ttf_pkg::SRC_DU1, ttf_pkg::SRC_E2Z, ttf_pkg::SRC_DU2, ttf_pkg::SRC_E1Z,
                  2'd2, ttf_pkg::VEC_B};
      4'd7: o = '{ttf_pkg::SRC_TY, ttf_pkg::SRC_BZ, ttf_pkg::SRC_TZ, ttf_pkg::SRC_BY,
                  2'd0, ttf_pkg::VEC_N};
      4'd8: o = '{ttf_pkg::SRC_TZ, ttf_pkg::SRC_BX, ttf_pkg::SRC_TX, ttf_pkg::SRC_BZ,
                  2'd1, ttf_pkg::VEC_N};
      4'd9: o = '{ttf_pkg::SRC_TX, ttf_pkg::SRC_BY, ttf_pkg::SRC_TY, ttf_pkg::SRC_BX,
                  2'd2, ttf_pkg::VEC_N};
      default: ;
    endcase
    return o;
  endfunction

  function automatic ttf_pkg::src_t comp_src(input ttf_pkg::vec_t v, input logic [1:0] c);
    ttf_pkg::src_t s;
    s = ttf_pkg::SRC_TX;
    case ({v, c})
      {ttf_pkg::VEC_T, 2'd1}: s = ttf_pkg::SRC_TY;
      {ttf_pkg::VEC_T, 2'd2}: s = ttf_pkg::SRC_TZ;
      {ttf_pkg::VEC_B, 2'd0}: s = ttf_pkg::SRC_BX;
      {ttf_pkg::VEC_B, 2'd1}: s = ttf_pkg::SRC_BY;
      {ttf_pkg::VEC_B, 2'd2}: s = ttf_pkg::SRC_BZ;
      {ttf_pkg::VEC_N, 2'd0}: s = ttf_pkg::SRC_NX;
      {ttf_pkg::VEC_N, 2'd1}: s = ttf_pkg::SRC_NY;
      {ttf_pkg::VEC_N, 2'd2}: s = ttf_pkg::SRC_NZ;
      default: ;
    endcase
    return s;
  endfunction

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    pair_nxt  = pair_r;
    sub_nxt   = sub_r;
    vec_nxt   = vec_r;
    comp_nxt  = comp_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    ops       = pair_ops(pair_r);
    csrc      = comp_src(vec_r, comp_r);
    unique case (vec_r)
      ttf_pkg::VEC_T: rbase = 4'd0;
      ttf_pkg::VEC_B: rbase = 4'd3;
      default:        rbase = 4'd6;
    endcase

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (phase_r != 2'd2) begin
            cmd.store_corner = 1'b1;
            cmd.corner_sel   = phase_r[0];
            phase_nxt        = phase_r + 2'd1;
          end else begin
            cmd.load_diff = 1'b1;
            phase_nxt     = 2'd0;
            pair_nxt      = 4'd0;
            sub_nxt       = 3'd0;
            state_nxt     = S_PAIR;
          end
        end
      end
      S_PAIR: begin
        case (sub_r)
          3'd0: begin
            cmd.a_src  = ops.a0;
            cmd.b_src  = ops.b0;
            cmd.acc_op = ttf_pkg::ACC_LOAD;
            sub_nxt    = sub_r + 3'd1;
          end
          3'd1: begin
            cmd.a_src  = ops.a1;
            cmd.b_src  = ops.b1;
            cmd.acc_op = ttf_pkg::ACC_SUB;
            sub_nxt    = sub_r + 3'd1;
          end
          3'd2: sub_nxt = sub_r + 3'd1;
          default: begin
            sub_nxt = 3'd0;
            if (pair_r == 4'd0) begin
              cmd.latch_det = 1'b1;
              if (stat.acc_zero) begin
                cmd.set_bad = 1'b1;
                state_nxt   = S_PUT;
              end else begin
                pair_nxt = pair_r + 4'd1;
              end
            end else begin
              cmd.latch_tri = 1'b1;
              cmd.tri_idx   = ops.idx;
              cmd.vec       = ops.vec;
              if (ops.idx == 2'd2) begin
                vec_nxt   = ops.vec;
                state_nxt = S_SCALE;
              end else begin
                pair_nxt = pair_r + 4'd1;
              end
            end
          end
        endcase
      end
      S_SCALE: begin
        cmd.vec = vec_r;
        if (sub_r == 3'd0) begin
          cmd.scale_load = 1'b1;
          sub_nxt        = 3'd1;
        end else if (stat.scale_zero) begin
          cmd.set_bad = 1'b1;
          state_nxt   = S_PUT;
        end else if (stat.scale_done) begin
          cmd.scale_store = 1'b1;
          sub_nxt         = 3'd0;
          unique case (vec_r)
            ttf_pkg::VEC_T: begin
              pair_nxt  = 4'd4;
              state_nxt = S_PAIR;
            end
            ttf_pkg::VEC_B: begin
              pair_nxt  = 4'd7;
              state_nxt = S_PAIR;
            end
            default: begin
              vec_nxt   = ttf_pkg::VEC_T;
              comp_nxt  = 2'd0;
              state_nxt = S_SQ;
            end
          endcase
        end else begin
          cmd.scale_step = 1'b1;
        end
      end
      // sum of squares of the current vector
      S_SQ: begin
        case (sub_r) inside
          3'd0, 3'd1, 3'd2: begin
            cmd.a_src  = comp_src(vec_r, sub_r[1:0]);
            cmd.b_src  = comp_src(vec_r, sub_r[1:0]);
            cmd.acc_op = (sub_r == 3'd0) ? ttf_pkg::ACC_LOAD : ttf_pkg::ACC_ADD;
            sub_nxt    = sub_r + 3'd1;
          end
          3'd3: sub_nxt = sub_r + 3'd1;
          default: begin
            cmd.sq_start = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_SQRT;
          end
        endcase
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == ttf_pkg::CNT_W'(ttf_pkg::SQRT_STEPS - 1)) begin
          comp_nxt  = 2'd0;
          sub_nxt   = 3'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_src = csrc;
        if (sub_r == 3'd0) begin
          cmd.div_start = 1'b1;
          sub_nxt       = 3'd1;
          cnt_nxt       = '0;
        end else if (cnt_r != ttf_pkg::CNT_W'(ttf_pkg::QW)) begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          cmd.res_write = 1'b1;
          cmd.res_idx   = rbase + 4'(comp_r);
          sub_nxt       = 3'd0;
          if (comp_r == 2'd2) begin
            unique case (vec_r)
              ttf_pkg::VEC_T: begin
                vec_nxt   = ttf_pkg::VEC_B;
                state_nxt = S_SQ;
              end
              ttf_pkg::VEC_B: begin
                vec_nxt   = ttf_pkg::VEC_N;
                state_nxt = S_SQ;
              end
              default: state_nxt = S_PUT;
            endcase
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      S_PUT: begin
        if (!stat.out_busy) begin
          cmd.put   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 2'd0;
      pair_r  <= 4'd0;
      sub_r   <= 3'd0;
      vec_r   <= ttf_pkg::VEC_T;
      comp_r  <= 2'd0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pair_r  <= pair_nxt;
      sub_r   <= sub_nxt;
      vec_r   <= vec_nxt;
      comp_r  <= comp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_third_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && phase_r == 2'd2) |=> (state_r == S_PAIR && phase_r == 2'd0))
    else $error("third vertex did not start a triangle");

  a_phase_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (phase_r == 2'd0))
    else $error("corner count not cleared while working");

  a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (cnt_r < ttf_pkg::CNT_W'(ttf_pkg::SQRT_STEPS)))
    else $error("square root ran past its step count");

endmodule

// ----- src/triangle_tangent_frame_core.sv -----
// Flow: the first and second vertex of a triangle go to the corner store when taken;
//   the third starts products, scaling, square roots and divisions, and no vertex is
//   taken again until the frame is in the output register. The time per triangle is
//   set by the 32-step square root and nine 16-step divisions on one datapath.
// Reset: synchronous, active low; clears the sequencer, corner count and output valid.
// ----------------------------------------------------------------------------
// triangle_tangent_frame_core: per-triangle tangent, binormal and normal
// Takes vertices in threes and returns the unit frame of each triangle.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_core (
  input  logic               clk,
  input  logic               rst_n,
  ttf_vtx_if.sink            in_vtx,
  ttf_frame_if.source        out_frame
);

  ttf_pkg::dp_cmd_t  cmd;
  ttf_pkg::dp_stat_t stat;
  ttf_pkg::vtx_t     vtx;
  ttf_pkg::frame_t   res;
  logic              res_valid;
  logic              in_ready;

  // vertex payload
  assign vtx.pos_x = in_vtx.pos_x;
  assign vtx.pos_y = in_vtx.pos_y;
  assign vtx.pos_z = in_vtx.pos_z;
  assign vtx.tex_u = in_vtx.tex_u;
  assign vtx.tex_v = in_vtx.tex_v;
  assign in_vtx.ready = in_ready;

  ttf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_vtx.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ttf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .vtx       (vtx),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_frame.ready)
  );

  // result channel
  assign out_frame.valid       = res_valid;
  assign out_frame.tangent_x   = res.tangent_x;
  assign out_frame.tangent_y   = res.tangent_y;
  assign out_frame.tangent_z   = res.tangent_z;
  assign out_frame.bitangent_x = res.bitangent_x;
  assign out_frame.bitangent_y = res.bitangent_y;
  assign out_frame.bitangent_z = res.bitangent_z;
  assign out_frame.normal_x    = res.normal_x;
  assign out_frame.normal_y    = res.normal_y;
  assign out_frame.normal_z    = res.normal_z;
  assign out_frame.degenerate  = res.degenerate;

endmodule
